@@ hw/rtl/multilevel_feedback_scheduler_macros.svh @@
// Assertion macros for the multilevel feedback scheduler.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
// Implication checked every clock, quiet during reset.
`define MFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, quiet during reset.
`define MFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/mfs_pkg.sv @@
// Shared types and codes of the multilevel feedback scheduler.
package mfs_pkg;
  localparam logic [2:0] EV_STAYED   = 3'd0;
  localparam logic [2:0] EV_DEMOTED  = 3'd1;
  localparam logic [2:0] EV_EXITED   = 3'd2;
  localparam logic [2:0] EV_BOOSTED  = 3'd3;
  localparam logic [2:0] EV_ADMITTED = 3'd4;
  localparam logic [2:0] EV_NONE     = 3'd5;
  localparam logic       CMD_ADMIT   = 1'b0;
  localparam logic [1:0] OUT_YIELD   = 2'd0;
  localparam logic [1:0] OUT_FULL    = 2'd1;
  localparam int unsigned REG_LEVELS = 0;
  localparam int unsigned REG_BOOST  = 1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;     // capture input beat
    logic sel;      // pick highest non-empty level
    logic pop;      // pop head of cur level
    logic push;     // push admitted id or head of cur level
    logic emit;     // load output register
    logic bsel;     // pick next drain level
    logic boost_clr;
  } mfs_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_admit;
    logic admit_ok;
    logic found;
    logic bfound;
    logic boost_due;
    logic out_busy;
  } mfs_stat_t;
endpackage

@@ hw/rtl/mfs_if.sv @@
// Valid/ready channel interfaces of the scheduler.
interface mfs_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] proc_id;
  logic [1:0] slice_outcome;
  modport source (output valid, cmd, proc_id, slice_outcome, input ready);
  modport sink (input valid, cmd, proc_id, slice_outcome, output ready);
endinterface

interface mfs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [3:0] proc_id_out;
  logic [3:0] level_out;
  logic       last_of_run;
  modport source (output valid, event_kind, proc_id_out, level_out, last_of_run,
                  input ready);
  modport sink (input valid, event_kind, proc_id_out, level_out, last_of_run,
                output ready);
endinterface

@@ hw/rtl/mfs_ctrl.sv @@
// Sequencing controller of the scheduler.
module mfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mfs_pkg::mfs_stat_t stat,
  output mfs_pkg::mfs_cmd_t  cmd
);
  import mfs_pkg::*;
  `include "multilevel_feedback_scheduler_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_BSEL  = 3'd3;
  localparam logic [2:0] S_BMOVE = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_admit) begin
          if (!stat.admit_ok) state_next = S_IDLE;
          else if (!stat.out_busy) begin
            cmd.push = 1'b1;
            cmd.emit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.sel = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          if (stat.found) begin
            cmd.pop = 1'b1;
            cmd.push = 1'b1;
          end
          if (stat.boost_due) begin
            cmd.boost_clr = 1'b1;
            cmd.bsel = 1'b1;
            state_next = S_BSEL;
          end else state_next = S_IDLE;
        end
      end
      S_BSEL: begin
        if (stat.bfound) state_next = S_BMOVE;
        else state_next = S_IDLE;
      end
      S_BMOVE: begin
        if (!stat.out_busy) begin
          cmd.pop = 1'b1;
          cmd.push = 1'b1;
          cmd.emit = 1'b1;
          cmd.bsel = 1'b1;
          state_next = S_BSEL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  `MFS_ASSERT_IMP(a_emit_free, cmd.emit, !stat.out_busy, "emit into busy output")
  `MFS_ASSERT_NXT(a_load_dec, cmd.load, state == S_DEC, "load did not decode")
  `MFS_ASSERT_IMP(a_ready_idle, in_ready, !cmd.push && !cmd.pop, "queue op while ready")
endmodule

@@ hw/rtl/mfs_dp.sv @@
// Queue datapath of the scheduler: links, heads, tails, counts, output.
module mfs_dp #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_LEVELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_cmd,
  input  logic [3:0]        in_pid,
  input  logic [1:0]        in_outcome,
  input  logic [3:0]        levels_in_use,
  input  logic [15:0]       boost_period,
  input  mfs_pkg::mfs_cmd_t cmd,
  output mfs_pkg::mfs_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        event_kind,
  output logic [3:0]        proc_id_out,
  output logic [3:0]        level_out,
  output logic              last_of_run
);
  import mfs_pkg::*;
  `include "multilevel_feedback_scheduler_macros.svh"

  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  logic [3:0]  next_link [MAX_PROCS];
  logic [3:0]  level_head [MAX_LEVELS];
  logic [3:0]  level_tail [MAX_LEVELS];
  logic [CW-1:0] level_count [MAX_LEVELS];
  logic [MAX_PROCS-1:0] queued;
  logic [15:0] boost_counter;

  logic        r_cmd;
  logic [3:0]  r_pid;
  logic [1:0]  r_outcome;
  logic [LW-1:0] cur, dst, top;
  logic        found, bfound;
  logic [3:0]  mv_id;

  // Top index with out-of-range clamping.
  always_comb begin
    if (levels_in_use == 4'd0) top = '0;
    else if (32'(levels_in_use) > MAX_LEVELS) top = LW'(MAX_LEVELS - 1);
    else top = LW'(levels_in_use - 4'd1);
  end

  logic [LW-1:0] hi_lv;
  logic          hi_any;
  always_comb begin
    hi_lv = '0;
    hi_any = 1'b0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (level_count[i] != '0) begin
        hi_lv = LW'(i);
        hi_any = 1'b1;
      end
    end
  end

  logic [15:0] bc_inc;
  assign bc_inc = boost_counter + 16'd1;
  logic pid_ok;
  assign pid_ok = 32'(r_pid) < MAX_PROCS;

  assign stat.is_admit  = (r_cmd == CMD_ADMIT);
  assign stat.admit_ok  = pid_ok && !queued[r_pid[$clog2(MAX_PROCS)-1:0]];
  assign stat.found     = found;
  assign stat.bfound    = bfound;
  assign stat.boost_due = (boost_period != 16'd0) && (bc_inc >= boost_period);
  assign stat.out_busy  = out_valid && !out_ready;

  // Destination and id of the push for this command.
  logic [LW-1:0] push_lv;
  logic [3:0]    push_id;
  logic          retire;
  always_comb begin
    push_lv = top;
    push_id = r_pid;
    retire = 1'b0;
    if (!stat.is_admit) begin
      push_id = mv_id;
      if (bfound) push_lv = top;
      else if (r_outcome == OUT_YIELD) push_lv = cur;
      else if (r_outcome == OUT_FULL) push_lv = (cur != '0) ? cur - LW'(1) : '0;
      else retire = 1'b1;
    end
  end
  assign dst = push_lv;
  assign mv_id = level_head[cur];

  // Push writes the head when the level is empty once the pop lands.
  logic push_en, push_head;
  assign push_en = cmd.push && !retire;
  assign push_head = (level_count[dst] == '0) ||
                     (cmd.pop && dst == cur && level_count[cur] == CW'(1));

  // Occupancy after this cycle's pop and push land; the next drain level is
  // the highest level other than the top that still holds entries.
  logic [MAX_LEVELS-1:0] ne_next;
  logic [LW-1:0]         drain_lv;
  logic                  drain_any_next;
  always_comb begin
    ne_next = '0;
    drain_lv = '0;
    drain_any_next = 1'b0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (push_en && dst == LW'(i)) ne_next[i] = 1'b1;
      else if (cmd.pop && cur == LW'(i)) ne_next[i] = level_count[i] > CW'(1);
      else ne_next[i] = level_count[i] != '0;
      if (ne_next[i] && LW'(i) != top) begin
        drain_lv = LW'(i);
        drain_any_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_cmd <= in_cmd;
      r_pid <= in_pid;
      r_outcome <= in_outcome;
      bfound <= 1'b0;
    end
    if (cmd.sel) begin
      cur <= hi_lv;
      found <= hi_any;
    end
    if (cmd.bsel) cur <= drain_lv;
    // Pop then push; a push into a level the pop empties takes the head.
    if (cmd.pop && !(push_en && push_head && dst == cur))
      level_head[cur] <= next_link[mv_id];
    if (push_en) begin
      if (push_head) level_head[dst] <= push_id;
      else next_link[level_tail[dst]] <= push_id;
      level_tail[dst] <= push_id;
    end
    if (cmd.emit) begin
      if (stat.is_admit) begin
        event_kind <= EV_ADMITTED;
        proc_id_out <= r_pid;
        level_out <= 4'(top) + 4'd1;
      end else if (bfound) begin
        event_kind <= EV_BOOSTED;
        proc_id_out <= mv_id;
        level_out <= 4'(top) + 4'd1;
      end else if (!found) begin
        event_kind <= EV_NONE;
        proc_id_out <= 4'd0;
        level_out <= 4'd0;
      end else if (retire) begin
        event_kind <= EV_EXITED;
        proc_id_out <= mv_id;
        level_out <= 4'd0;
      end else begin
        event_kind <= (r_outcome == OUT_YIELD) ? EV_STAYED : EV_DEMOTED;
        proc_id_out <= mv_id;
        level_out <= 4'(dst) + 4'd1;
      end
      // Last beat unless a boost leaves a drain level after this update.
      if (stat.is_admit) last_of_run <= 1'b1;
      else if (bfound || stat.boost_due) last_of_run <= !drain_any_next;
      else last_of_run <= 1'b1;
    end
    if (rst) begin
      out_valid <= 1'b0;
      queued <= '0;
      boost_counter <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) level_count[i] <= '0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.emit && !stat.is_admit && !bfound)
        boost_counter <= cmd.boost_clr ? 16'd0 : bc_inc;
      if (cmd.bsel) bfound <= drain_any_next;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        level_count[i] <= level_count[i]
          - CW'(cmd.pop && cur == LW'(i))
          + CW'(push_en && dst == LW'(i));
      end
      if (cmd.pop && retire) queued[mv_id[$clog2(MAX_PROCS)-1:0]] <= 1'b0;
      if (push_en) queued[push_id[$clog2(MAX_PROCS)-1:0]] <= 1'b1;
    end
  end

  `MFS_ASSERT_IMP(a_pop_nonempty, cmd.pop, level_count[cur] != '0, "pop of empty level")
  `MFS_ASSERT_NXT(a_emit_valid, cmd.emit, out_valid, "emit lost")
  `MFS_ASSERT_IMP(a_bst_top, cmd.emit && bfound, cur != top, "boost from top level")
endmodule

@@ hw/rtl/multilevel_feedback_scheduler.sv @@
// Top level of the multilevel feedback queue scheduler.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      cmd, proc_id, slice_outcome
//  out_ch   out  valid/ready      event_kind, proc_id_out, level_out, last_of_run
//  apb      in   psel/penable     levels_in_use (0x0), boost_period (0x4)
//
// An admit passes the idle and decode states, a run idle, decode and run; a run
// that triggers a boost adds a boost select, plus a move and a select for each
// process moved by the boost, sequenced by the controller over the single queue datapath.
// rst is synchronous: counts, queued flags and the boost counter clear; links
// need no clearing. A stalled output beat holds the sequencer in place.
module multilevel_feedback_scheduler #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_LEVELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  mfs_in_if.sink      in_ch,
  mfs_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mfs_pkg::*;

  logic [3:0]  levels_in_use;
  logic [15:0] boost_period;
  mfs_cmd_t    cmd;
  mfs_stat_t   stat;

  assign pready = 1'b1;

  // Register writes at the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= 4'd3;
      boost_period <= 16'd100;
    end else if (psel && penable && pwrite) begin
      if (32'(paddr[2]) == REG_LEVELS) levels_in_use <= pwdata[3:0];
      else if (32'(paddr[2]) == REG_BOOST) boost_period <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      1'b0: prdata = {28'd0, levels_in_use};
      default: prdata = {16'd0, boost_period};
    endcase
  end

  mfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  mfs_dp #(.MAX_PROCS(MAX_PROCS), .MAX_LEVELS(MAX_LEVELS)) u_dp (
    .clk(clk), .rst(rst),
    .in_cmd(in_ch.cmd), .in_pid(in_ch.proc_id), .in_outcome(in_ch.slice_outcome),
    .levels_in_use(levels_in_use), .boost_period(boost_period),
    .cmd(cmd), .stat(stat),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .event_kind(out_ch.event_kind), .proc_id_out(out_ch.proc_id_out),
    .level_out(out_ch.level_out), .last_of_run(out_ch.last_of_run)
  );
endmodule
